// ===== src/cdsu_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsu_pkg: shared types and constants of the concentric disk sample unit
// Word formats, pipeline cell records, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cdsu_pkg;

	localparam int IN_BITS       = 16;
	localparam int OUT_FRAC_BITS = 15;
	localparam int ANG_FRAC      = 30;
	localparam int DIV_STEPS     = 30;
	localparam int ROT_STEPS     = 30;
	localparam int OUT_SHIFT     = IN_BITS + ANG_FRAC - OUT_FRAC_BITS;

	localparam logic [29:0] PI4_Q30  = 30'h3243F6A8;
	localparam logic signed [31:0] GAIN_INV = 32'sh26DD3B6A;

	typedef struct packed {
		logic [IN_BITS-1:0] u_first;
		logic [IN_BITS-1:0] u_second;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_FRAC_BITS:0] disk_x;
		logic signed [OUT_FRAC_BITS:0] disk_y;
	} point_t;

	// radius, branch and sine sign carried alongside the math
	typedef struct packed {
		logic signed [IN_BITS+1:0] r;
		logic                      first;
		logic                      neg;
	} ctx_t;

	typedef struct packed {
		logic              vld;
		logic [IN_BITS:0]  rem;
		logic [IN_BITS:0]  den;
		logic [ANG_FRAC:0] quo;
		ctx_t              ctx;
	} div_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		ctx_t               ctx;
	} rot_t;

	// atan(2^-step) in Q2.30, truncated (steps 27 to 29 rounded up)
	function automatic logic signed [31:0] atan_q30(input int step);
		logic signed [31:0] a;
		case (step)
			0:  a = 32'sh3243F6A8;
			1:  a = 32'sh1DAC6705;
			2:  a = 32'sh0FADBAFC;
			3:  a = 32'sh07F56EA6;
			4:  a = 32'sh03FEAB76;
			5:  a = 32'sh01FFD55B;
			6:  a = 32'sh00FFFAAA;
			7:  a = 32'sh007FFF55;
			8:  a = 32'sh003FFFEA;
			9:  a = 32'sh001FFFFD;
			10: a = 32'sh000FFFFF;
			11: a = 32'sh0007FFFF;
			12: a = 32'sh0003FFFF;
			13: a = 32'sh0001FFFF;
			14: a = 32'sh0000FFFF;
			15: a = 32'sh00007FFF;
			16: a = 32'sh00003FFF;
			17: a = 32'sh00001FFF;
			18: a = 32'sh00000FFF;
			19: a = 32'sh000007FF;
			20: a = 32'sh000003FF;
			21: a = 32'sh000001FF;
			22: a = 32'sh000000FF;
			23: a = 32'sh0000007F;
			24: a = 32'sh0000003F;
			25: a = 32'sh0000001F;
			26: a = 32'sh0000000F;
			27: a = 32'sh00000008;
			28: a = 32'sh00000004;
			29: a = 32'sh00000002;
			default: a = 32'sh00000000;
		endcase
		return a;
	endfunction

endpackage

// ===== src/cdsu_div_cell.sv =====
// ----------------------------------------------------------------------------
// cdsu_div_cell: one restoring division step
// Doubles the remainder, subtracts the divisor when it fits, shifts in a bit.
// ----------------------------------------------------------------------------
module cdsu_div_cell
	import cdsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  div_t din,
	output div_t dout
);

	logic [IN_BITS+1:0] trial;
	logic               fits;
	div_t               nxt;

	// trial subtract of the doubled remainder
	always_comb begin
		trial = {din.rem, 1'b0};
		fits  = trial >= {1'b0, din.den};
		nxt   = din;
		nxt.rem = fits ? (IN_BITS+1)'(trial - {1'b0, din.den}) : (IN_BITS+1)'(trial);
		nxt.quo = {din.quo[ANG_FRAC-1:0], fits};
	end

	// advance when the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== src/cdsu_rot_cell.sv =====
// ----------------------------------------------------------------------------
// cdsu_rot_cell: one CORDIC rotation step
// Rotates (x, y) by +/- atan(2^-STEP) toward a zero residual angle.
// ----------------------------------------------------------------------------
module cdsu_rot_cell
	import cdsu_pkg::*;
#(
	parameter int STEP = 0
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  rot_t din,
	output rot_t dout
);

	localparam logic signed [31:0] ANGLE = atan_q30(STEP);

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	rot_t               nxt;

	// rotate by the sign of the residual angle
	always_comb begin
		dx  = din.y >>> STEP;
		dy  = din.x >>> STEP;
		nxt = din;
		if (!din.z[31]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ANGLE;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ANGLE;
		end
	end

	// advance when the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== src/cdsu_out_stage.sv =====
// ----------------------------------------------------------------------------
// cdsu_out_stage: radius scaling, rounding and saturation
// Multiplies radius by cosine and sine magnitudes, then rounds and clamps.
// ----------------------------------------------------------------------------
module cdsu_out_stage
	import cdsu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  rot_t   din,
	output logic   vld,
	output point_t dout
);

	localparam int MAG_W = IN_BITS + 1 + 32;
	localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (OUT_SHIFT - 1);
	localparam logic [MAG_W-OUT_SHIFT:0] LIM = (MAG_W-OUT_SHIFT+1)'(1) << OUT_FRAC_BITS;

	logic signed [31:0] s_val;
	logic signed [31:0] ta;
	logic signed [31:0] tb;
	logic [IN_BITS:0]   r_mag;
	logic [31:0]        ta_mag;
	logic [31:0]        tb_mag;

	logic               vld_s1;
	logic [MAG_W-1:0]   ma_s1;
	logic [MAG_W-1:0]   mb_s1;
	logic               na_s1;
	logic               nb_s1;

	// pick cosine and sine per branch, take magnitudes
	always_comb begin
		s_val  = din.ctx.neg ? -din.y : din.y;
		ta     = din.ctx.first ? din.x : s_val;
		tb     = din.ctx.first ? s_val : din.x;
		r_mag  = din.ctx.r[IN_BITS+1] ? (IN_BITS+1)'(-din.ctx.r)
		                              : din.ctx.r[IN_BITS:0];
		ta_mag = ta[31] ? 32'(-ta) : 32'(ta);
		tb_mag = tb[31] ? 32'(-tb) : 32'(tb);
	end

	// round to nearest, ties away, then clamp a magnitude to signed range
	function automatic logic signed [OUT_FRAC_BITS:0] finish(input logic [MAG_W-1:0] m,
	                                                           input logic neg);
		logic [MAG_W-OUT_SHIFT:0] q;
		logic [MAG_W-OUT_SHIFT:0] c;
		logic [OUT_FRAC_BITS:0]   res;
		q = (MAG_W-OUT_SHIFT+1)'(({1'b0, m} + {1'b0, HALF}) >> OUT_SHIFT);
		if (neg) begin
			c   = (q > LIM) ? LIM : q;
			res = (OUT_FRAC_BITS+1)'(-c);
		end else begin
			c   = (q > LIM - 1'b1) ? LIM - 1'b1 : q;
			res = (OUT_FRAC_BITS+1)'(c);
		end
		return $signed(res);
	endfunction

	// register the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ma_s1  <= '0;
			mb_s1  <= '0;
			na_s1  <= 1'b0;
			nb_s1  <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.vld;
			ma_s1  <= MAG_W'(r_mag) * MAG_W'(ta_mag);
			mb_s1  <= MAG_W'(r_mag) * MAG_W'(tb_mag);
			na_s1  <= din.ctx.r[IN_BITS+1] ^ ta[31];
			nb_s1  <= din.ctx.r[IN_BITS+1] ^ tb[31];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld  <= 1'b0;
			dout <= '0;
		end else if (en) begin
			vld         <= vld_s1;
			dout.disk_x <= finish(ma_s1, na_s1);
			dout.disk_y <= finish(mb_s1, nb_s1);
		end
	end

endmodule

// ===== src/concentric_disk_sample_unit.sv =====
// ----------------------------------------------------------------------------
// concentric_disk_sample_unit: square-to-disk concentric mapping
// Fixed-point pipeline: divider cells, angle scale, CORDIC cells, output scale.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel sample/sample_valid/sample_ready carries one word with two
//   unsigned Q0.16 square coordinates. Output channel point/point_valid/
//   point_ready carries the disk point as two signed Q1.15 values.
//   The datapath is one chain of registered cells: a front stage, thirty
//   restoring division cells, one angle multiply stage, thirty CORDIC cells,
//   a product stage and the output register. A new word is taken every
//   cycle while the output is not stalled, giving one word per cycle.
//   The whole chain advances together; when the output word is held by the
//   receiver and not taken, the chain freezes and sample_ready drops for that
//   cycle. Reset clears every stage valid bit; no words are in flight after it.
// ----------------------------------------------------------------------------
module concentric_disk_sample_unit
	import cdsu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    point_valid,
	input  logic    point_ready,
	output point_t  point
);

	logic en;

	logic signed [IN_BITS+1:0] xs;
	logic signed [IN_BITS+1:0] ys;
	logic [IN_BITS:0]          xm;
	logic [IN_BITS:0]          ym;
	logic                      first;
	logic [IN_BITS:0]          nm;
	logic [IN_BITS:0]          dm;
	div_t                      front;

	div_t div_w [0:DIV_STEPS];
	rot_t rot_w [0:ROT_STEPS];
	rot_t rot_in;
	logic [ANG_FRAC+30:0] phi_full;

	// whole chain moves unless the output word is stuck
	assign en           = !point_valid || point_ready;
	assign sample_ready = en;

	// remap to [-1,1), choose branch, seed the divider
	always_comb begin
		xs    = $signed({1'b0, sample.u_first, 1'b0}) - $signed((IN_BITS+2)'(1) << IN_BITS);
		ys    = $signed({1'b0, sample.u_second, 1'b0}) - $signed((IN_BITS+2)'(1) << IN_BITS);
		xm    = xs[IN_BITS+1] ? (IN_BITS+1)'(-xs) : xs[IN_BITS:0];
		ym    = ys[IN_BITS+1] ? (IN_BITS+1)'(-ys) : ys[IN_BITS:0];
		first = xm > ym;
		nm    = first ? ym : xm;
		dm    = first ? xm : ym;
		front.vld       = sample_valid;
		front.rem       = (nm == dm) ? '0 : nm;
		front.den       = dm;
		front.quo       = {{ANG_FRAC{1'b0}}, nm == dm};
		front.ctx.r     = first ? xs : ys;
		front.ctx.first = first;
		front.ctx.neg   = xs[IN_BITS+1] ^ ys[IN_BITS+1];
	end

	// front stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_w[0] <= '0;
		end else if (en) begin
			div_w[0] <= front;
		end
	end

	// division cells
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		cdsu_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (div_w[i]),
			.dout   (div_w[i+1])
		);
	end

	// scale the ratio by pi/4 and seed the rotator
	assign phi_full = (ANG_FRAC+31)'(div_w[DIV_STEPS].quo) * (ANG_FRAC+31)'(PI4_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_in <= '0;
		end else if (en) begin
			rot_in.vld <= div_w[DIV_STEPS].vld;
			rot_in.x   <= GAIN_INV;
			rot_in.y   <= '0;
			rot_in.z   <= $signed({1'b0, phi_full[ANG_FRAC+30:ANG_FRAC]});
			rot_in.ctx <= div_w[DIV_STEPS].ctx;
		end
	end

	assign rot_w[0] = rot_in;

	// CORDIC cells
	for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
		cdsu_rot_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (rot_w[k]),
			.dout   (rot_w[k+1])
		);
	end

	// radius scaling and output register
	cdsu_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (rot_w[ROT_STEPS]),
		.vld    (point_valid),
		.dout   (point)
	);

`ifndef SYNTHESIS
	// a stalled output freezes the front of the chain too
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_ready) |=> $stable(div_w[0]))
		else $error("front stage moved during stall");

	// input is refused exactly while the output word waits
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready == (!point_valid || point_ready))
		else $error("ready does not follow output stall");

	// the rotator always starts from the inverse gain with zero y
	a_rot_seed: assert property (@(posedge clk) disable iff (!arst_n)
		rot_in.vld |-> (rot_in.x == GAIN_INV && rot_in.y == 32'sd0))
		else $error("rotator seed corrupted");
`endif

endmodule
